### hw/rtl/rational_root_search_top_assert.svh
// assertion macros for the rational root search block
`ifndef RATIONAL_ROOT_SEARCH_TOP_ASSERT_SVH
`define RATIONAL_ROOT_SEARCH_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define RRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rrs_pkg.sv
package rrs_pkg;

    localparam logic [1:0] OUTCOME_ROOT    = 2'd0;
    localparam logic [1:0] OUTCOME_NO_ROOT = 2'd1;
    localparam logic [1:0] OUTCOME_INVALID = 2'd2;

    localparam int WIDE_BITS  = 128;
    // horner arithmetic runs one chunk of the wide words per cycle
    localparam int CHUNK_BITS = 32;

    // controller to datapath commands
    typedef struct packed {
        logic load;         // store incoming coefficient
        logic setup;        // latch lc and tc magnitudes
        logic q_init;       // q <= 1
        logic q_inc;        // q <= q + 1
        logic p_init;       // p <= 1, positive
        logic p_inc;        // p <= p + 1, positive
        logic set_neg;      // candidate sign negative
        logic div_start;    // start remainder unit
        logic div_sel_tc;   // remainder of tc (else lc) by p (else q)
        logic ev_init;      // horner init
        logic ev_dp;        // den power times q, one chunk
        logic ev_acc;       // accumulator times signed p, one chunk
        logic ev_term;      // accumulator plus den power times coefficient, one chunk
    } rrs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic degree_zero;
        logic lc_zero;
        logic tc_zero;
        logic q_done;       // q > |lc|
        logic p_done;       // p > |tc|
        logic div_busy;
        logic div_zero;     // remainder is zero
        logic ev_last;      // horner index passed degree
        logic ch_last;      // final chunk of a wide operation
        logic acc_zero;
        logic neg;
    } rrs_stat_t;

endpackage

### hw/rtl/rational_root_search_top.sv
// Rational root search. Coefficients arrive one request per cycle, highest
// degree first, while busy is low; the request with last_coef high is the
// constant term and starts the search, raising busy until the result strobe.
// The result appears for exactly one cycle with done high and cannot be
// stalled: the receiver must take it then. Search time depends on the data:
// each divisor test of q or p runs start, the shared bit-serial remainder
// unit and a decision, and each candidate evaluation runs in the Horner
// unit (per coefficient one loop state plus three passes of four 32-bit
// chunks over the 128-bit words: den power times q, accumulator times p,
// accumulator plus term); the search tries each q up to |lc| and, for each
// q that divides lc, each p up to |tc|, evaluating each pair that divides.
module rational_root_search_top #(
    parameter int unsigned MAX_DEGREE = 6,
    parameter int unsigned COEF_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] coef_value,
    input  logic        last_coef,
    output logic        done,
    output logic [1:0]  outcome,
    output logic [16:0] root_numerator,
    output logic [15:0] root_denominator
);
    import rrs_pkg::*;

    rrs_cmd_t    cmd;
    rrs_stat_t   stat;
    logic        use_root;
    logic [16:0] dp_num;
    logic [15:0] dp_den;

    // sequencer: loading, divisor search, candidate tests
    rrs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_coef(last_coef),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .outcome  (outcome),
        .use_root (use_root)
    );

    // coefficient store, candidate counters, remainder unit, horner unit
    rrs_datapath #(
        .MAX_DEGREE (MAX_DEGREE),
        .COEF_BITS  (COEF_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .coef_value       (coef_value),
        .last_coef        (last_coef),
        .stat             (stat),
        .root_numerator   (dp_num),
        .root_denominator (dp_den)
    );

    // zero constant term and failures report 0/1
    assign root_numerator   = use_root ? dp_num : 17'd0;
    assign root_denominator = use_root ? dp_den : 16'd1;
endmodule

### hw/rtl/rrs_divider.sv
module rrs_divider #(
    parameter int unsigned W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic         rem_zero
);
    // restoring divider, one quotient bit a cycle, remainder only
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[W-1:0], dvd_reg[W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            rem_next = trial[W] ? shifted : trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign rem_zero = (rem_reg == '0);
endmodule

### hw/rtl/rrs_datapath.sv
module rrs_datapath #(
    parameter int unsigned MAX_DEGREE = 6,
    parameter int unsigned COEF_BITS  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rrs_pkg::rrs_cmd_t  cmd,
    input  logic [15:0]     coef_value,
    input  logic            last_coef,
    output rrs_pkg::rrs_stat_t stat,
    output logic [16:0]     root_numerator,
    output logic [15:0]     root_denominator
);
    import rrs_pkg::*;

    localparam int unsigned DEPTH = MAX_DEGREE + 1;
    localparam int unsigned IW    = $clog2(DEPTH + 1);
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned MW    = COEF_BITS + 1;
    localparam int unsigned PW    = CHUNK_BITS + MW;
    localparam logic [1:0]  CH_LAST = 2'(WIDE_BITS / CHUNK_BITS - 1);

    logic signed [COEF_BITS-1:0] store_mem [DEPTH];
    logic [IW-1:0]    cnt_reg, cnt_next;
    logic [IW-1:0]    deg_reg;
    logic [MW-1:0]    lc_reg, tc_reg;
    logic [MW-1:0]    q_reg, p_reg;
    logic             neg_reg;
    logic [IW-1:0]    idx_reg;
    logic [1:0]       ch_reg;
    logic [WIDE_BITS-1:0] acc_reg, dp_reg;
    logic [MW-1:0]    mc_reg;
    logic             ac_reg;
    logic signed [COEF_BITS-1:0] coef_in;
    logic signed [COEF_BITS-1:0] rd_coef;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic [MW-1:0]    div_a, div_b;
    logic             div_busy, div_zero;
    logic signed [COEF_BITS-1:0] lc_s, tc_s;
    logic [MW-1:0]    coef_mag;
    logic [CHUNK_BITS-1:0] ch_src, ch_base;
    logic [MW-1:0]    ch_mag;
    logic             ch_neg;
    logic             ch_active;
    logic [MW-1:0]    mc_in;
    logic             c_in;
    logic [PW-1:0]    ch_prod;
    logic [CHUNK_BITS-1:0] ch_part;
    logic [CHUNK_BITS:0]   ch_sum;

    assign coef_in = coef_value[COEF_BITS-1:0];

    // store write: append, or overwrite final entry with a marked item when full
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(DEPTH - 1);
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            if (cnt_reg < IW'(DEPTH))
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + 1'b1;
            end
            else if (last_coef)
                wr_en = 1'b1;
            if (last_coef)
                cnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= coef_in;
    end

    assign lc_s    = store_mem[0];
    assign tc_s    = store_mem[deg_reg[AW-1:0]];
    assign rd_coef = store_mem[idx_reg[AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // degree latched with the last item (count after write minus one)
    always_ff @(posedge clk)
    begin
        if (cmd.load && last_coef)
            deg_reg <= (cnt_reg < IW'(DEPTH)) ? cnt_reg : IW'(DEPTH - 1);
        if (cmd.setup)
        begin
            lc_reg <= lc_s[COEF_BITS-1] ? MW'(-$signed({lc_s[COEF_BITS-1], lc_s}))
                                        : MW'(lc_s);
            tc_reg <= tc_s[COEF_BITS-1] ? MW'(-$signed({tc_s[COEF_BITS-1], tc_s}))
                                        : MW'(tc_s);
        end
        if (cmd.q_init)
            q_reg <= MW'(1);
        else if (cmd.q_inc)
            q_reg <= q_reg + 1'b1;
        if (cmd.p_init)
        begin
            p_reg   <= MW'(1);
            neg_reg <= 1'b0;
        end
        else if (cmd.p_inc)
        begin
            p_reg   <= p_reg + 1'b1;
            neg_reg <= 1'b0;
        end
        else if (cmd.set_neg)
            neg_reg <= 1'b1;
    end

    assign div_a = cmd.div_sel_tc ? tc_reg : lc_reg;
    assign div_b = cmd.div_sel_tc ? p_reg : q_reg;

    rrs_divider #(.W(MW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .rem_zero (div_zero)
    );

    // horner on wide words, one chunk a cycle, low chunk first:
    // each word rotates right so the working chunk is always at the bottom
    // a negative factor is applied as the complement plus a carry-in of one
    assign coef_mag = rd_coef[COEF_BITS-1] ? MW'(-$signed({rd_coef[COEF_BITS-1], rd_coef}))
                                           : MW'(rd_coef);
    assign ch_active = cmd.ev_dp || cmd.ev_acc || cmd.ev_term;

    always_comb
    begin
        ch_src  = dp_reg[CHUNK_BITS-1:0];
        ch_mag  = q_reg;
        ch_neg  = 1'b0;
        ch_base = '0;
        if (cmd.ev_acc)
        begin
            ch_src = acc_reg[CHUNK_BITS-1:0];
            ch_mag = p_reg;
            ch_neg = neg_reg;
        end
        else if (cmd.ev_term)
        begin
            ch_mag  = coef_mag;
            ch_neg  = rd_coef[COEF_BITS-1];
            ch_base = acc_reg[CHUNK_BITS-1:0];
        end
    end

    assign mc_in   = (ch_reg == 2'd0) ? '0 : mc_reg;
    assign c_in    = (ch_reg == 2'd0) ? ch_neg : ac_reg;
    assign ch_prod = PW'(ch_src) * PW'(ch_mag) + PW'(mc_in);
    assign ch_part = ch_neg ? ~ch_prod[CHUNK_BITS-1:0] : ch_prod[CHUNK_BITS-1:0];
    assign ch_sum  = {1'b0, ch_base} + {1'b0, ch_part} + (CHUNK_BITS + 1)'(c_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ch_reg <= '0;
        else if (cmd.ev_init)
            ch_reg <= '0;
        else if (ch_active)
            ch_reg <= ch_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ev_init)
        begin
            acc_reg <= WIDE_BITS'(lc_s);
            dp_reg  <= WIDE_BITS'(1);
            idx_reg <= IW'(1);
        end
        else if (cmd.ev_dp)
            dp_reg <= {ch_sum[CHUNK_BITS-1:0], dp_reg[WIDE_BITS-1:CHUNK_BITS]};
        else if (cmd.ev_acc)
            acc_reg <= {ch_sum[CHUNK_BITS-1:0], acc_reg[WIDE_BITS-1:CHUNK_BITS]};
        else if (cmd.ev_term)
        begin
            acc_reg <= {ch_sum[CHUNK_BITS-1:0], acc_reg[WIDE_BITS-1:CHUNK_BITS]};
            dp_reg  <= {dp_reg[CHUNK_BITS-1:0], dp_reg[WIDE_BITS-1:CHUNK_BITS]};
            if (ch_reg == CH_LAST)
                idx_reg <= idx_reg + 1'b1;
        end
        if (ch_active)
        begin
            mc_reg <= ch_prod[PW-1:CHUNK_BITS];
            ac_reg <= ch_sum[CHUNK_BITS];
        end
    end

    assign stat.degree_zero = (deg_reg == '0);
    assign stat.lc_zero     = (lc_s == '0);
    assign stat.tc_zero     = (tc_s == '0);
    assign stat.q_done      = (q_reg > lc_reg);
    assign stat.p_done      = (p_reg > tc_reg);
    assign stat.div_busy    = div_busy;
    assign stat.div_zero    = div_zero;
    assign stat.ev_last     = (idx_reg > deg_reg);
    assign stat.ch_last     = (ch_reg == CH_LAST);
    assign stat.acc_zero    = (acc_reg == '0);
    assign stat.neg         = neg_reg;

    assign root_numerator   = neg_reg ? 17'(-$signed({1'b0, p_reg})) : 17'(p_reg);
    assign root_denominator = 16'(q_reg);
endmodule

### hw/rtl/rrs_controller.sv
module rrs_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            last_coef,
    input  rrs_pkg::rrs_stat_t stat,
    output rrs_pkg::rrs_cmd_t  cmd,
    output logic            busy,
    output logic            done,
    output logic [1:0]      outcome,
    output logic            use_root
);
    import rrs_pkg::*;

    `include "rational_root_search_top_assert.svh"

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SETUP  = 4'd1;
    localparam logic [3:0] ST_QDIV   = 4'd2;
    localparam logic [3:0] ST_QWAIT  = 4'd3;
    localparam logic [3:0] ST_PDIV   = 4'd4;
    localparam logic [3:0] ST_PWAIT  = 4'd5;
    localparam logic [3:0] ST_EINIT  = 4'd6;
    localparam logic [3:0] ST_ENEXT  = 4'd7;
    localparam logic [3:0] ST_EDP    = 4'd8;
    localparam logic [3:0] ST_EACC   = 4'd9;
    localparam logic [3:0] ST_ETERM  = 4'd10;
    localparam logic [3:0] ST_CHECK  = 4'd11;
    localparam logic [3:0] ST_REPORT = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] outc_reg, outc_next;
    logic       root_reg, root_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        outc_next  = outc_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_coef)
                        state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                cmd.q_init = 1'b1;
                if (stat.degree_zero || stat.lc_zero)
                begin
                    outc_next  = OUTCOME_INVALID;
                    root_next  = 1'b0;
                    state_next = ST_REPORT;
                end
                else if (stat.tc_zero)
                begin
                    outc_next  = OUTCOME_ROOT;
                    root_next  = 1'b0;
                    state_next = ST_REPORT;
                end
                else
                    state_next = ST_QDIV;
            end
            ST_QDIV:
            begin
                if (stat.q_done)
                begin
                    outc_next  = OUTCOME_NO_ROOT;
                    root_next  = 1'b0;
                    state_next = ST_REPORT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_QWAIT;
                end
            end
            ST_QWAIT:
            begin
                if (!stat.div_busy)
                begin
                    if (stat.div_zero)
                    begin
                        cmd.p_init = 1'b1;
                        state_next = ST_PDIV;
                    end
                    else
                    begin
                        cmd.q_inc  = 1'b1;
                        state_next = ST_QDIV;
                    end
                end
            end
            ST_PDIV:
            begin
                if (stat.p_done)
                begin
                    cmd.q_inc  = 1'b1;
                    state_next = ST_QDIV;
                end
                else
                begin
                    cmd.div_start  = 1'b1;
                    cmd.div_sel_tc = 1'b1;
                    state_next     = ST_PWAIT;
                end
            end
            ST_PWAIT:
            begin
                cmd.div_sel_tc = 1'b1;
                if (!stat.div_busy)
                begin
                    if (stat.div_zero)
                        state_next = ST_EINIT;
                    else
                    begin
                        cmd.p_inc  = 1'b1;
                        state_next = ST_PDIV;
                    end
                end
            end
            ST_EINIT:
            begin
                cmd.ev_init = 1'b1;
                state_next  = ST_ENEXT;
            end
            ST_ENEXT:
            begin
                if (stat.ev_last)
                    state_next = ST_CHECK;
                else
                    state_next = ST_EDP;
            end
            ST_EDP:
            begin
                cmd.ev_dp = 1'b1;
                if (stat.ch_last)
                    state_next = ST_EACC;
            end
            ST_EACC:
            begin
                cmd.ev_acc = 1'b1;
                if (stat.ch_last)
                    state_next = ST_ETERM;
            end
            ST_ETERM:
            begin
                cmd.ev_term = 1'b1;
                if (stat.ch_last)
                    state_next = ST_ENEXT;
            end
            ST_CHECK:
            begin
                if (stat.acc_zero)
                begin
                    outc_next  = OUTCOME_ROOT;
                    root_next  = 1'b1;
                    state_next = ST_REPORT;
                end
                else if (!stat.neg)
                begin
                    cmd.set_neg = 1'b1;
                    state_next  = ST_EINIT;
                end
                else
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = ST_PDIV;
                end
            end
            ST_REPORT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            outc_reg  <= OUTCOME_NO_ROOT;
            root_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            outc_reg  <= outc_next;
            root_reg  <= root_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign outcome  = outc_reg;
    assign use_root = root_reg;

    `RRS_ASSERT_NEXT(a_report_done, clk, rst_n, state_reg == ST_REPORT, done_reg,
        "report state without result strobe")
    `RRS_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE,
        "result strobe outside idle")
    `RRS_ASSERT_IMPL(a_root_outcome, clk, rst_n, done_reg && root_reg,
        outc_reg == OUTCOME_ROOT, "found root without root outcome")
endmodule

### bench/rrs_checker.sv
module rrs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] coef_value,
    input  logic        last_coef,
    input  logic        done,
    input  logic [1:0]  outcome,
    input  logic [16:0] root_numerator,
    input  logic [15:0] root_denominator,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rrs_pkg::*;

    localparam int DEPTH = 7;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [16:0] num;
        logic [15:0] den;
    } root_report_t;

    root_report_t report_q[$];
    int coef_mem[DEPTH];
    int coef_cnt;

    // q^n * P(p/q) by horner, exact at 128 bits
    function automatic logic signed [127:0] scaled_value(int n, longint p, longint q);
        logic signed [127:0] acc;
        logic signed [127:0] qpow;
        acc  = coef_mem[0];
        qpow = 1;
        for (int i = 1; i <= n; i++)
        begin
            qpow = qpow * q;
            acc  = acc * p + coef_mem[i] * qpow;
        end
        return acc;
    endfunction

    function automatic root_report_t search_root();
        root_report_t r;
        int n;
        longint lc;
        longint tc;
        longint lm;
        longint tm;
        bit found;
        r.outcome = OUTCOME_NO_ROOT;
        r.num     = '0;
        r.den     = 16'd1;
        n  = coef_cnt - 1;
        lc = coef_mem[0];
        tc = coef_mem[n];
        found = 0;
        if (n == 0 || lc == 0)
        begin
            r.outcome = OUTCOME_INVALID;
        end
        else if (tc == 0)
        begin
            r.outcome = OUTCOME_ROOT;
        end
        else
        begin
            lm = (lc < 0) ? -lc : lc;
            tm = (tc < 0) ? -tc : tc;
            for (longint q = 1; q <= lm && !found; q++)
            begin
                if (lm % q == 0)
                begin
                    for (longint p = 1; p <= tm && !found; p++)
                    begin
                        if (tm % p == 0)
                        begin
                            if (scaled_value(n, p, q) == 0)
                            begin
                                found = 1;
                                r.num = 17'(p);
                            end
                            else if (scaled_value(n, -p, q) == 0)
                            begin
                                found = 1;
                                r.num = 17'(-p);
                            end
                            if (found)
                            begin
                                r.outcome = OUTCOME_ROOT;
                                r.den     = 16'(q);
                            end
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, int exp_v, int act_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        coef_cnt   = 0;
    end

    always @(posedge clk)
    begin
        root_report_t exp_r;
        if (rst_n)
        begin
            // results first: a new request cannot produce this cycle's strobe
            if (done)
            begin
                if (report_q.size() == 0)
                begin
                    note_mismatch("unexpected result, outcome", -1, int'(outcome));
                end
                else
                begin
                    exp_r = report_q.pop_front();
                    checked++;
                    if (outcome !== exp_r.outcome)
                        note_mismatch("outcome", int'(exp_r.outcome), int'(outcome));
                    if (root_numerator !== exp_r.num)
                        note_mismatch("root_numerator", int'($signed(exp_r.num)),
                                      int'($signed(root_numerator)));
                    if (root_denominator !== exp_r.den)
                        note_mismatch("root_denominator", int'(exp_r.den),
                                      int'(root_denominator));
                end
            end
            if (start && !busy)
            begin
                if (coef_cnt < DEPTH)
                begin
                    coef_mem[coef_cnt] = $signed(coef_value);
                    coef_cnt++;
                end
                else if (last_coef)
                begin
                    coef_mem[DEPTH-1] = $signed(coef_value);
                end
                if (last_coef)
                begin
                    report_q = {report_q, search_root()};
                    coef_cnt = 0;
                end
            end
            pending = report_q.size();
        end
    end

endmodule

### bench/tb_rational_root_search_top.sv
module tb_rational_root_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 60000000;
    localparam int RANDOM_COEFS = 700;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] coef_value;
    logic        last_coef;
    logic        done;
    logic [1:0]  outcome;
    logic [16:0] root_numerator;
    logic [15:0] root_denominator;

    int fail_count;
    int pending;
    int checked;
    int cycles;
    int coefs_sent;
    int polys_sent;
    bit burst_mode;

    rational_root_search_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .coef_value       (coef_value),
        .last_coef        (last_coef),
        .done             (done),
        .outcome          (outcome),
        .root_numerator   (root_numerator),
        .root_denominator (root_denominator)
    );

    // scoreboard sits beside the block and watches both sides
    rrs_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .coef_value       (coef_value),
        .last_coef        (last_coef),
        .done             (done),
        .outcome          (outcome),
        .root_numerator   (root_numerator),
        .root_denominator (root_denominator),
        .fail_count       (fail_count),
        .pending          (pending),
        .checked          (checked)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog: a hung search ends the run
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("rational_root_search_top verification failed");
            $finish;
        end
    end

    // one coefficient request, held until the block takes it
    task automatic send_coef(int v, bit is_last);
        @(negedge clk);
        start      <= 1'b1;
        coef_value <= v[15:0];
        last_coef  <= is_last;
        do
            @(posedge clk);
        while (busy);
        coefs_sent++;
    endtask

    // mostly short gaps, now and then a long one, none in burst mode
    task automatic idle_gap();
        int n;
        n = 0;
        if (!burst_mode)
            n = ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 2))
                                           : int'($urandom_range(3, 40));
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // whole polynomial, highest degree first, last item marked
    task automatic send_poly(int coefs[$]);
        foreach (coefs[i])
        begin
            send_coef(coefs[i], i == coefs.size() - 1);
            idle_gap();
        end
        polys_sent++;
    endtask

    function automatic int rnd_range(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int rnd_full();
        return rnd_range(-32768, 32767);
    endfunction

    // small magnitudes keep the divisor search short
    function automatic int rnd_small_nz();
        int v;
        v = rnd_range(1, 31);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    // (q x - p) times a small random cofactor: a known rational root
    function automatic void make_factored(ref int c[$]);
        int d;
        int q;
        int p;
        int b[$];
        d = rnd_range(1, 6);
        q = rnd_range(1, 4);
        p = rnd_range(-5, 5);
        b = {};
        for (int i = 0; i < d; i++)
            b = {b, rnd_range(-3, 3)};
        if (b[0] == 0)
            b[0] = 1;
        c = {};
        for (int i = 0; i <= d; i++)
            c = {c, 0};
        for (int i = 0; i < d; i++)
        begin
            c[i]   += q * b[i];
            c[i+1] += -p * b[i];
        end
    endfunction

    task automatic random_poly();
        int c[$];
        int kind;
        int d;
        c = {};
        kind = $urandom_range(0, 99);
        d = rnd_range(1, 6);
        if (kind < 45)
        begin
            make_factored(c);
        end
        else if (kind < 72)
        begin
            // full-range inner terms, small ends
            c = {c, rnd_small_nz()};
            for (int i = 1; i < d; i++)
                c = {c, rnd_full()};
            c = {c, rnd_small_nz()};
        end
        else if (kind < 79)
        begin
            // zero leading coefficient
            c = {c, 0};
            for (int i = 0; i < d; i++)
                c = {c, rnd_full()};
        end
        else if (kind < 84)
        begin
            // degree zero
            c = {c, rnd_full()};
        end
        else if (kind < 90)
        begin
            // more items than the store holds: extras dropped, last replaces
            c = {c, rnd_small_nz()};
            for (int i = 0; i < rnd_range(6, 9); i++)
                c = {c, rnd_full()};
            c = {c, rnd_small_nz()};
        end
        else
        begin
            // full-range leading term with zero constant: quick exit
            c = {c, rnd_full()};
            for (int i = 1; i < d; i++)
                c = {c, rnd_full()};
            c = {c, 0};
        end
        send_poly(c);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        coef_value = '0;
        last_coef  = 1'b0;
        coefs_sent = 0;
        polys_sent = 0;
        burst_mode = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed polynomials, back to back
        send_poly('{1, 0});                 // root at zero
        send_poly('{0, 5});                 // leading coefficient zero
        send_poly('{7});                    // degree zero
        send_poly('{32767, -32767});        // root 1/1 at the positive extreme
        send_poly('{-32768, -32768});       // root -1/1, negative tried second
        send_poly('{2, -1});                // root 1/2
        send_poly('{-32768, 0});            // most negative lead, zero constant
        send_poly('{0, 0});                 // zero lead takes precedence
        send_poly('{1, 0, 1});              // no rational root
        send_poly('{1, 32767, -32768, 0});  // extreme inner terms
        send_poly('{1, 2, 3, 4, 5, 6, 7, 8, -1}); // store overflow
        send_poly('{1, 1, 1, 1, 1, 1, 1});  // full degree six
        send_poly('{6, -5, 1});             // roots 1/3 and 1/2, 1/2 is first

        // random part with random gaps
        while (coefs_sent < RANDOM_COEFS + 40)
        begin
            burst_mode = ($urandom_range(0, 4) == 0);
            random_poly();
        end

        @(negedge clk);
        start <= 1'b0;

        // drain, then let the block settle
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("sent %0d coefficients in %0d polynomials, checked %0d results",
                 coefs_sent, polys_sent, checked);
        if (fail_count == 0 && pending == 0)
            $display("rational_root_search_top verification clean");
        else
            $display("rational_root_search_top verification failed");
        $finish;
    end

endmodule
